// File: hdl/counting_semaphore_wait_queue_unit_assert.svh
// Assertion macros for the counting semaphore wait queue unit.
// Depends on a clk and an rst signal in the scope of use.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/csq_pkg.sv
// Package for the counting semaphore wait queue unit.
// Holds state, request and status codes and the control structs; no dependencies.
package csq_pkg;

  localparam int UNIT_BITS = 16;
  localparam int STATUS_BITS = 4;
  localparam int REQ_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_WAIT = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_SIGNAL = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_FLUSH = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_ACQUIRED = 4'd0;
  localparam logic [STATUS_BITS-1:0] ST_BLOCKED = 4'd1;
  localparam logic [STATUS_BITS-1:0] ST_TIMEOUT = 4'd2;
  localparam logic [STATUS_BITS-1:0] ST_ISR = 4'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 4'd4;
  localparam logic [STATUS_BITS-1:0] ST_INCR = 4'd5;
  localparam logic [STATUS_BITS-1:0] ST_ATMAX = 4'd6;
  localparam logic [STATUS_BITS-1:0] ST_WOKEN = 4'd7;
  localparam logic [STATUS_BITS-1:0] ST_NOFLUSH = 4'd8;

  localparam logic CFG_MAX_COUNT = 1'b0;
  localparam logic CFG_INITIAL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flush_busy;
    logic total_one;
    logic out_free;
  } ctrl_stat_t;

endpackage

// File: hdl/csq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/csq_ctrl.sv
// Controller state machine for the counting semaphore wait queue unit.
// Depends on csq_pkg for the state type and the command and status structs.
module csq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  csq_pkg::ctrl_stat_t stat,
  output csq_pkg::ctrl_cmd_t  cmd
);

  csq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    cmd = '0;
    unique case (state)
      csq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next = csq_pkg::S_EXEC;
        end
      end
      csq_pkg::S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec = 1'b1;
          state_next = stat.flush_busy ? csq_pkg::S_FLUSH : csq_pkg::S_IDLE;
        end
      end
      csq_pkg::S_FLUSH: begin
        if (stat.out_free) begin
          cmd.pop = 1'b1;
          if (stat.total_one) begin
            state_next = csq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = csq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/csq_datapath.sv
// Datapath of the counting semaphore wait queue unit: count, queue pointers,
// waiter RAM and output register. Depends on csq_pkg and csq_ram.
module csq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csq_pkg::ctrl_cmd_t                   cmd,
  output csq_pkg::ctrl_stat_t                  stat,
  input  logic [csq_pkg::REQ_BITS-1:0]         req_type,
  input  logic [TASK_BITS-1:0]                 task_id,
  input  logic                                 no_wait,
  input  logic                                 from_isr,
  input  logic                                 cfg_we,
  input  logic                                 cfg_addr,
  input  logic [csq_pkg::UNIT_BITS-1:0]        cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [csq_pkg::STATUS_BITS-1:0]      out_status,
  output logic [TASK_BITS-1:0]                 out_task,
  output logic [csq_pkg::UNIT_BITS-1:0]        out_units,
  output logic                                 out_last
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [csq_pkg::REQ_BITS-1:0]    in_req;
  logic [TASK_BITS-1:0]            in_task;
  logic                            in_no_wait;
  logic                            in_isr;
  logic [csq_pkg::UNIT_BITS-1:0]   units, units_next;
  logic [csq_pkg::UNIT_BITS-1:0]   max_count;
  logic [PTR_BITS-1:0]             head, head_next;
  logic [PTR_BITS-1:0]             tail, tail_next;
  logic [CNT_BITS-1:0]             total, total_next;
  logic                            total_zero;
  logic                            wr_en;
  logic [TASK_BITS-1:0]            rd_task;
  logic                            emit;
  logic [csq_pkg::STATUS_BITS-1:0] res_status;
  logic [TASK_BITS-1:0]            res_task;
  logic                            res_last;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  assign total_zero = (total == '0);
  assign stat.flush_busy = (in_req == csq_pkg::REQ_FLUSH) && !total_zero;
  assign stat.total_one = (total == CNT_BITS'(1));
  assign stat.out_free = !out_valid || out_ready;

  csq_ram #(
    .WIDTH(TASK_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_waiters (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail),
    .wdata(in_task),
    .raddr(head_next),
    .rdata(rd_task)
  );

  always_comb begin
    units_next = units;
    head_next = head;
    tail_next = tail;
    total_next = total;
    wr_en = 1'b0;
    emit = 1'b0;
    res_status = csq_pkg::ST_ACQUIRED;
    res_task = '0;
    res_last = 1'b1;
    if (cmd.exec) begin
      case (in_req)
        csq_pkg::REQ_WAIT: begin
          emit = 1'b1;
          if (in_isr) begin
            res_status = csq_pkg::ST_ISR;
          end else if (units != '0) begin
            units_next = units - csq_pkg::UNIT_BITS'(1);
            res_status = csq_pkg::ST_ACQUIRED;
          end else if (in_no_wait) begin
            res_status = csq_pkg::ST_TIMEOUT;
          end else if (total == CNT_BITS'(QUEUE_DEPTH)) begin
            res_status = csq_pkg::ST_FULL;
          end else begin
            wr_en = 1'b1;
            tail_next = ptr_inc(tail);
            total_next = total + CNT_BITS'(1);
            res_status = csq_pkg::ST_BLOCKED;
          end
        end
        csq_pkg::REQ_SIGNAL: begin
          emit = 1'b1;
          if (!total_zero) begin
            head_next = ptr_inc(head);
            total_next = total - CNT_BITS'(1);
            res_status = csq_pkg::ST_WOKEN;
            res_task = rd_task;
          end else if (units < max_count) begin
            units_next = units + csq_pkg::UNIT_BITS'(1);
            res_status = csq_pkg::ST_INCR;
          end else begin
            res_status = csq_pkg::ST_ATMAX;
          end
        end
        csq_pkg::REQ_FLUSH: begin
          if (total_zero) begin
            emit = 1'b1;
            res_status = csq_pkg::ST_NOFLUSH;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.pop) begin
      emit = 1'b1;
      head_next = ptr_inc(head);
      total_next = total - CNT_BITS'(1);
      res_status = csq_pkg::ST_WOKEN;
      res_task = rd_task;
      res_last = stat.total_one;
    end
    if (cfg_we && cfg_addr == csq_pkg::CFG_INITIAL_COUNT) begin
      units_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      units <= '0;
      max_count <= csq_pkg::UNIT_BITS'(1);
      head <= '0;
      tail <= '0;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      units <= units_next;
      head <= head_next;
      tail <= tail_next;
      total <= total_next;
      if (cfg_we && cfg_addr == csq_pkg::CFG_MAX_COUNT) begin
        max_count <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_req <= req_type;
      in_task <= task_id;
      in_no_wait <= no_wait;
      in_isr <= from_isr;
    end
    if (emit) begin
      out_status <= res_status;
      out_task <= res_task;
      out_units <= units_next;
      out_last <= res_last;
    end
  end

endmodule

// File: hdl/counting_semaphore_wait_queue_unit.sv
// Counting semaphore with a first-in first-out queue of blocked tasks.
// An item is accepted in idle and registered; the execute state registers a wait or signal result
// when the output is free. A flush goes from the execute state to the flush state, which pops
// one waiter per cycle from the waiter RAM read port while the output is free.
// Synchronous reset: count 0, max_count 1, queue empty, output empty.
// Depends on csq_pkg, csq_ctrl, csq_datapath, csq_ram and the assertion header.
`include "counting_semaphore_wait_queue_unit_assert.svh"
module counting_semaphore_wait_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_BITS = 6,
  localparam int IN_W = ((TASK_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_W = ((TASK_BITS + csq_pkg::UNIT_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // task_id, no_wait, from_isr
  input  logic [IN_W-1:0]                    s_tdata,
  // req_type
  input  logic [csq_pkg::REQ_BITS-1:0]       s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // woken_task, units_now
  output logic [OUT_W-1:0]                   m_tdata,
  // status
  output logic [csq_pkg::STATUS_BITS-1:0]    m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_addr,
  input  logic [csq_pkg::UNIT_BITS-1:0]      cfg_data
);

  csq_pkg::ctrl_cmd_t  cmd;
  csq_pkg::ctrl_stat_t stat;
  logic [TASK_BITS-1:0]          out_task;
  logic [csq_pkg::UNIT_BITS-1:0] out_units;

  assign cfg_ready = 1'b1;
  assign m_tdata = OUT_W'({out_units, out_task});

  csq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  csq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TASK_BITS  (TASK_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req_type  (s_tuser),
    .task_id   (s_tdata[TASK_BITS-1:0]),
    .no_wait   (s_tdata[TASK_BITS]),
    .from_isr  (s_tdata[TASK_BITS+1]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_status(m_tuser),
    .out_task  (out_task),
    .out_units (out_units),
    .out_last  (m_tlast)
  );

  `CSQ_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready)
  `CSQ_ASSERT_NEXT(a_flush_ends_idle, cmd.pop && stat.total_one, s_tready)
  `CSQ_ASSERT_SAME(a_one_command, 1'b1, $onehot0({cmd.load_in, cmd.exec, cmd.pop}))
  `CSQ_ASSERT_SAME(a_single_result_last, m_tvalid && m_tuser != csq_pkg::ST_WOKEN, m_tlast)

endmodule
